// ===== src/affine_2d_transform_builder_assert.svh =====
// Assertion macros for the affine transform builder
`ifndef AFFINE_2D_TRANSFORM_BUILDER_ASSERT_SVH
`define AFFINE_2D_TRANSFORM_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define AFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/afb_pkg.sv =====
package afb_pkg;
  localparam int unsigned ANGLE_BITS = 24;
  localparam int unsigned CORDIC_W   = 34;
  localparam int unsigned ZW         = 36;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] Q90  = 36'sd1509949440;
  localparam logic signed [35:0] Q180 = 36'sd3019898880;
  localparam logic signed [35:0] Q270 = 36'sd4529848320;
  localparam logic signed [35:0] Q360 = 36'sd6039797760;

  // atan(2^-i) in 2^-24 degree units
  function automatic logic signed [35:0] atan_step(input int unsigned i);
    logic [63:0] base;
    logic [63:0] v;
    begin
      base = 64'd961263668;
      case (i)
        0:  v = 64'd754974720;
        1:  v = 64'd445687602;
        2:  v = 64'd235489088;
        3:  v = 64'd119537938;
        4:  v = 64'd60000934;
        5:  v = 64'd30029717;
        6:  v = 64'd15018523;
        7:  v = 64'd7509720;
        8:  v = 64'd3754917;
        9:  v = 64'd1877466;
        10: v = 64'd938734;
        11: v = 64'd469367;
        default: v = (base + (64'd1 << (i - 1))) >> i;
      endcase
      atan_step = v[35:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic f);
    begin
      f = 1'b0;
      if (v > 66'sd2147483647) begin
        f = 1'b1; sat32 = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
        f = 1'b1; sat32 = 32'sh80000000;
      end else begin
        sat32 = v[31:0];
      end
    end
  endfunction
endpackage

// ===== src/afb_cordic_stage.sv =====
module afb_cordic_stage
  import afb_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  logic signed [ZW-1:0]       z_in,
  output logic signed [CORDIC_W-1:0] x_r,
  output logic signed [CORDIC_W-1:0] y_r,
  output logic signed [ZW-1:0]       z_r
);
  localparam logic signed [ZW-1:0] ATAN = atan_step(STEP);
  logic signed [CORDIC_W-1:0] xs, ys;
  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_r <= x_in - ys; y_r <= y_in + xs; z_r <= z_in - ATAN;
      end else begin
        x_r <= x_in + ys; y_r <= y_in - xs; z_r <= z_in + ATAN;
      end
    end
  end
endmodule

// ===== src/affine_2d_transform_builder.sv =====
// 2D affine transform builder: one word in, one word out, one item per clock
// while the output is not stalled. The pipeline has angle reduction stages
// (reciprocal quotient, remainder, negate and fold), one CORDIC stage per
// iteration, then product, rounding/saturation, translation product and
// translation sum stages. The CORDIC chain length sets the latency; the whole
// pipeline advances together when the output register is free or being taken.
module affine_2d_transform_builder
  import afb_pkg::*;
#(
  parameter int unsigned ROTATION_ITERATIONS = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_rotation_deg,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_scale_x_cos,
  output logic signed [31:0] out_scale_y_cos,
  output logic signed [31:0] out_neg_scale_x_sin,
  output logic signed [31:0] out_scale_y_sin,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic               out_saturated
);
  localparam int unsigned NIT = (ROTATION_ITERATIONS > 32) ? 32 : ROTATION_ITERATIONS;
  localparam int unsigned LAT = NIT + 7;

  typedef struct packed {
    logic signed [31:0] sx, sy, ox, oy, px, py;
  } side_t;

  logic adv;
  logic [LAT-1:0] vld_r;
  side_t side_r [LAT];
  logic [NIT:0] flip_r;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{in_scale_x, in_scale_y, in_origin_x, in_origin_y, in_pos_x, in_pos_y};
      for (int k = 1; k < LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  // Stages 0 and 1: angle mod 360 degrees. Whole degrees are offset to be
  // nonnegative and divided by 360 with a reciprocal multiply (exact over
  // this range); fraction bits pass straight through.
  localparam logic signed [33:0] FULL = 34'sd360 <<< FRACTION_BITS;
  localparam longint HI_SPAN = longint'(1) <<< (31 - FRACTION_BITS);
  localparam longint HI_OFF = 360 * ((HI_SPAN + 359) / 360);
  localparam logic [31:0] LO_MASK = 32'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [25:0] RECIP = 26'd47721859; // ceil(2^34 / 360)
  logic [25:0] v0, v0_r;
  logic [16:0] q0, q0_r;
  logic [31:0] lo0_r;
  assign v0 = 26'(34'(in_rotation_deg >>> FRACTION_BITS) + 34'(HI_OFF));
  assign q0 = 17'((51'(v0) * 51'(RECIP)) >> 34);
  always_ff @(posedge clk) begin
    if (adv) begin
      v0_r <= v0; q0_r <= q0; lo0_r <= in_rotation_deg & LO_MASK;
    end
  end

  logic signed [33:0] r0_r;
  logic [8:0] hm1;
  assign hm1 = 9'(v0_r - 26'(q0_r) * 26'd360);
  always_ff @(posedge clk) begin
    if (adv) r0_r <= (34'(hm1) << FRACTION_BITS) | 34'(lo0_r);
  end

  // Stage 2: negate, rescale, fold
  logic signed [ZW-1:0] t1, z1_r;
  logic signed [33:0] tn;
  assign tn = (r0_r == '0) ? '0 : FULL - r0_r;
  assign t1 = ZW'(tn) <<< (ANGLE_BITS - FRACTION_BITS);
  always_ff @(posedge clk) begin
    if (adv) begin
      flip_r[0] <= 1'b0;
      if (t1 <= Q90) z1_r <= t1;
      else if (t1 >= Q270) z1_r <= t1 - Q360;
      else begin z1_r <= t1 - Q180; flip_r[0] <= 1'b1; end
      for (int k = 1; k <= NIT; k++) flip_r[k] <= flip_r[k-1];
    end
  end

  logic signed [CORDIC_W-1:0] cx [NIT+1];
  logic signed [CORDIC_W-1:0] cy [NIT+1];
  logic signed [ZW-1:0] cz [NIT+1];
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = z1_r;
  for (genvar g = 0; g < NIT; g++) begin : g_cordic
    afb_cordic_stage #(.STEP(g)) u_stage (
      .clk(clk), .en(adv), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .x_r(cx[g+1]), .y_r(cy[g+1]), .z_r(cz[g+1])
    );
  end

  // Products (Q(F+30)), flip folded in
  logic signed [CORDIC_W-1:0] c, s;
  assign c = flip_r[NIT] ? -cx[NIT] : cx[NIT];
  assign s = flip_r[NIT] ? -cy[NIT] : cy[NIT];
  side_t sp;
  assign sp = side_r[NIT+2];
  logic signed [65:0] pa_r, pbc_r, ps_r, pd_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= 66'(sp.sx) * 66'(c);
      pbc_r <= 66'(sp.sy) * 66'(c);
      ps_r <= 66'(sp.sx) * 66'(s);
      pd_r <= 66'(sp.sy) * 66'(s);
    end
  end

  // Round and saturate coefficients
  localparam logic signed [65:0] H30 = 66'sd1 <<< 29;
  logic signed [65:0] ra, rbc, rs, rd;
  assign ra = (pa_r + H30) >>> 30;
  assign rbc = (pbc_r + H30) >>> 30;
  assign rs = (ps_r + H30) >>> 30;
  assign rd = (pd_r + H30) >>> 30;
  logic signed [31:0] a_r, bc_r, ns_r, d_r, bs_r;
  logic sat1_r;
  logic fa, fb, fn, fd, fs;
  logic signed [31:0] a_n, bc_n, ns_n, d_n, bs_n;
  always_comb begin
    a_n = sat32(ra, fa);
    bc_n = sat32(rbc, fb);
    ns_n = sat32(-rs, fn);
    d_n = sat32(rd, fd);
    bs_n = sat32(rs, fs);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_n; bc_r <= bc_n; ns_r <= ns_n; d_r <= d_n; bs_r <= bs_n;
      sat1_r <= fa | fb | fn | fd | fs;
    end
  end

  // Translation products
  side_t st;
  assign st = side_r[NIT+4];
  logic signed [63:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [31:0] a2_r, bc2_r, ns2_r, d2_r;
  logic sat2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= 64'(st.ox) * 64'(a_r);
      m2_r <= 64'(st.oy) * 64'(d_r);
      m3_r <= 64'(st.ox) * 64'(bs_r);
      m4_r <= 64'(st.oy) * 64'(bc_r);
      a2_r <= a_r; bc2_r <= bc_r; ns2_r <= ns_r; d2_r <= d_r;
      sat2_r <= sat1_r;
    end
  end

  // Sum and saturate translation
  localparam logic signed [65:0] HF = 66'sd1 <<< (FRACTION_BITS - 1);
  side_t sf;
  assign sf = side_r[NIT+5];
  logic signed [65:0] txs, tys;
  logic ftx, fty;
  logic signed [31:0] tx_n, ty_n;
  always_comb begin
    txs = 66'(sf.px) - ((66'(m1_r) + HF) >>> FRACTION_BITS)
                     - ((66'(m2_r) + HF) >>> FRACTION_BITS);
    tys = 66'(sf.py) + ((66'(m3_r) + HF) >>> FRACTION_BITS)
                     - ((66'(m4_r) + HF) >>> FRACTION_BITS);
    tx_n = sat32(txs, ftx);
    ty_n = sat32(tys, fty);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_scale_x_cos <= a2_r;
      out_scale_y_cos <= bc2_r;
      out_neg_scale_x_sin <= ns2_r;
      out_scale_y_sin <= d2_r;
      out_trans_x <= tx_n;
      out_trans_y <= ty_n;
      out_saturated <= sat2_r | ftx | fty;
    end
  end

`include "affine_2d_transform_builder_assert.svh"
  // stalled output must stay valid and out_trans_x must hold
  `AFB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_trans_x))
  // ready follows output register state
  `AFB_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid, in_ready)
endmodule
